>>> hw/rtl/bvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode machine execute unit package
// Shared sizes, opcodes, controller command and datapath status types.
// ----------------------------------------------------------------------------
package bvm_pkg;

    // Machine sizes. STACK_BYTES and NUM_REGS are powers of two, so a wrap is
    // a part-select of the low address bits.
    localparam int NUM_REGS         = 16;
    localparam int STACK_BYTES      = 256;
    localparam int SP_REG_INDEX     = 0;
    localparam int STATUS_REG_INDEX = 1;
    localparam int CONST_BYTES      = 4;

    localparam int WORD_W = 32;
    localparam int MODE_W = 4;
    localparam int RIDX_W = 4;
    localparam int RF_AW  = $clog2(NUM_REGS);
    localparam int STK_AW = $clog2(STACK_BYTES);

    localparam logic [RF_AW-1:0] SP_IDX     = RF_AW'(SP_REG_INDEX % NUM_REGS);
    localparam logic [RF_AW-1:0] STATUS_IDX = RF_AW'(STATUS_REG_INDEX % NUM_REGS);

    typedef enum logic [MODE_W-1:0] {
        OP_MOVCONST = 4'd0,
        OP_MOVREG   = 4'd1,
        OP_PUSH     = 4'd2,
        OP_ADD      = 4'd3,
        OP_ADDREG   = 4'd4,
        OP_SUB      = 4'd5,
        OP_MUL      = 4'd6,
        OP_JMP      = 4'd7,
        OP_HALT     = 4'd8
    } op_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;    // latch the instruction and read its registers
        logic take_ops;   // latch the two register operands
        logic exec;       // perform the register-level part of the instruction
        logic pop;        // read one stack byte and step the pointer down
        logic alu;        // combine the two popped words
        logic push;       // step the pointer up and write one stack byte
        logic push_last;  // final pushed byte: write back pointer, advance pc
        logic load_out;   // copy the architectural results to the output
    } bvm_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic halted;
        logic is_push;
        logic is_arith;
    } bvm_stat_t;

    // Program counter advance for every opcode that does not jump.
    function automatic logic [WORD_W-1:0] pc_step(input logic [MODE_W-1:0] mode);
        logic [WORD_W-1:0] step;
        unique case (op_t'(mode))
            OP_MOVCONST: step = WORD_W'(2 + CONST_BYTES);
            OP_MOVREG:   step = WORD_W'(3);
            OP_PUSH:     step = WORD_W'(1 + CONST_BYTES);
            OP_ADDREG:   step = WORD_W'(3);
            default:     step = WORD_W'(1);
        endcase
        return step;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bvm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel carrying one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface bvm_in_if
    import bvm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [RIDX_W-1:0] reg_a;
    logic [RIDX_W-1:0] reg_b;
    logic [WORD_W-1:0] immediate;

    modport source (output valid, output mode, output reg_a, output reg_b,
                    output immediate, input ready);
    modport sink   (input valid, input mode, input reg_a, input reg_b,
                    input immediate, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bvm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one execution result per transfer.
// ----------------------------------------------------------------------------
interface bvm_out_if
    import bvm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] next_pc;
    logic              halted;
    logic [WORD_W-1:0] exit_status;

    modport source (output valid, output next_pc, output halted,
                    output exit_status, input ready);
    modport sink   (input valid, input next_pc, input halted,
                    input exit_status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bvm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Execute unit datapath
// Register file, byte stack, program counter, halt state and output register.
// ----------------------------------------------------------------------------
module bvm_datapath
    import bvm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bvm_cmd_t          cmd,
    output bvm_stat_t              stat,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [RIDX_W-1:0] reg_a,
    input  wire logic [RIDX_W-1:0] reg_b,
    input  wire logic [WORD_W-1:0] immediate,
    output logic [WORD_W-1:0]      next_pc,
    output logic                   halted,
    output logic [WORD_W-1:0]      exit_status
);

    // Latched instruction.
    logic [MODE_W-1:0] mode_reg;
    logic [RF_AW-1:0]  ra_reg;
    logic [RF_AW-1:0]  rb_reg;
    logic [WORD_W-1:0] imm_reg;

    // Register file with valid bits; an entry never written reads as zero.
    logic [WORD_W-1:0]   rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic [WORD_W-1:0]   rf_rd_a_reg;
    logic [WORD_W-1:0]   rf_rd_b_reg;
    logic [RF_AW-1:0]    rf_raddr_a;
    logic [RF_AW-1:0]    rf_raddr_b;
    logic                rf_we;
    logic [RF_AW-1:0]    rf_waddr;
    logic [WORD_W-1:0]   rf_wdata;

    // Byte stack, single port, with valid bits.
    logic [7:0]             stk_mem [STACK_BYTES];
    logic [STACK_BYTES-1:0] stk_vld_reg;
    logic [7:0]             stk_rd_reg;
    logic [STK_AW-1:0]      stk_addr;

    logic [WORD_W-1:0]   op_a_reg;
    logic [WORD_W-1:0]   op_b_reg;
    logic [WORD_W-1:0]   sp_reg;
    logic [WORD_W-1:0]   sp_inc;
    logic [WORD_W-1:0]   pc_reg;
    logic                halt_reg;
    logic [WORD_W-1:0]   hstat_reg;
    logic [2*WORD_W-1:0] pop_sh_reg;
    logic                pop_cap_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   alu_res;
    logic [WORD_W-1:0]   pop_x;
    logic [WORD_W-1:0]   pop_y;
    logic [WORD_W-1:0]   out_pc_reg;
    logic                out_halt_reg;
    logic [WORD_W-1:0]   out_stat_reg;

    assign stat.halted   = halt_reg;
    assign stat.is_push  = (mode_reg == OP_PUSH);
    assign stat.is_arith = (mode_reg == OP_ADD) || (mode_reg == OP_SUB)
                        || (mode_reg == OP_MUL);

    assign sp_inc = sp_reg + WORD_W'(1);
    assign pop_x  = pop_sh_reg[WORD_W-1:0];
    assign pop_y  = pop_sh_reg[2*WORD_W-1:WORD_W];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            ra_reg   <= RF_AW'(reg_a);
            rb_reg   <= RF_AW'(reg_b);
            imm_reg  <= immediate;
        end
    end

    // Register file ports. The instruction's registers are read as it is
    // taken; afterwards the ports read the stack pointer and status register.
    assign rf_raddr_a = cmd.capture ? RF_AW'(reg_a) : SP_IDX;
    assign rf_raddr_b = cmd.capture ? RF_AW'(reg_b) : STATUS_IDX;

    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = ra_reg;
        rf_wdata = imm_reg;
        if (cmd.exec)
        begin
            unique case (op_t'(mode_reg))
                OP_MOVCONST:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = imm_reg;
                end
                OP_MOVREG:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = op_b_reg;
                end
                OP_ADDREG:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = op_a_reg + op_b_reg;
                end
                default:
                begin
                    rf_we = 1'b0;
                end
            endcase
        end
        else if (cmd.push_last)
        begin
            rf_we    = 1'b1;
            rf_waddr = SP_IDX;
            rf_wdata = sp_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        rf_rd_a_reg <= rf_vld_reg[rf_raddr_a] ? rf_mem[rf_raddr_a] : '0;
        rf_rd_b_reg <= rf_vld_reg[rf_raddr_b] ? rf_mem[rf_raddr_b] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_vld_reg[rf_waddr] <= 1'b1;
        end
    end

    // Byte stack: pops read at the pointer, pushes write one above it.
    assign stk_addr = cmd.push ? sp_inc[STK_AW-1:0] : sp_reg[STK_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_mem[stk_addr] <= word_reg[WORD_W-1:WORD_W-8];
        end
        stk_rd_reg <= stk_vld_reg[stk_addr] ? stk_mem[stk_addr] : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stk_vld_reg <= '0;
        end
        else if (cmd.push)
        begin
            stk_vld_reg[stk_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        unique case (op_t'(mode_reg))
            OP_ADD:  alu_res = pop_x + pop_y;
            OP_SUB:  alu_res = pop_y - pop_x;
            default: alu_res = WORD_W'(pop_x * pop_y);
        endcase
    end

    // Working registers for stack operations.
    always_ff @(posedge clk)
    begin
        if (cmd.take_ops)
        begin
            op_a_reg <= rf_rd_a_reg;
            op_b_reg <= rf_rd_b_reg;
        end
        if (cmd.exec)
        begin
            sp_reg <= rf_rd_a_reg;
        end
        else if (cmd.pop)
        begin
            sp_reg <= sp_reg - WORD_W'(1);
        end
        else if (cmd.push)
        begin
            sp_reg <= sp_inc;
        end
        // The first byte popped ends up in the lowest byte.
        if (pop_cap_reg)
        begin
            pop_sh_reg <= {stk_rd_reg, pop_sh_reg[2*WORD_W-1:8]};
        end
        if (cmd.exec)
        begin
            word_reg <= imm_reg;
        end
        else if (cmd.alu)
        begin
            word_reg <= alu_res;
        end
        else if (cmd.push)
        begin
            word_reg <= {word_reg[WORD_W-9:0], 8'd0};
        end
        if (cmd.load_out)
        begin
            out_pc_reg   <= pc_reg;
            out_halt_reg <= halt_reg;
            out_stat_reg <= hstat_reg;
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            hstat_reg   <= '0;
            pop_cap_reg <= 1'b0;
        end
        else
        begin
            pop_cap_reg <= cmd.pop;
            if (cmd.exec)
            begin
                unique case (op_t'(mode_reg))
                    OP_JMP:
                    begin
                        pc_reg <= imm_reg;
                    end
                    OP_HALT:
                    begin
                        pc_reg    <= pc_reg + pc_step(mode_reg);
                        halt_reg  <= 1'b1;
                        hstat_reg <= rf_rd_b_reg;
                    end
                    OP_PUSH, OP_ADD, OP_SUB, OP_MUL:
                    begin
                        pc_reg <= pc_reg;
                    end
                    default:
                    begin
                        pc_reg <= pc_reg + pc_step(mode_reg);
                    end
                endcase
            end
            else if (cmd.push_last)
            begin
                pc_reg <= pc_reg + pc_step(mode_reg);
            end
        end
    end

    assign next_pc     = out_pc_reg;
    assign halted      = out_halt_reg;
    assign exit_status = out_stat_reg;

endmodule
`default_nettype wire

>>> hw/rtl/bvm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Execute unit sequencer
// Steps each instruction through register reads, stack pops and pushes.
// ----------------------------------------------------------------------------
module bvm_ctrl
    import bvm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire bvm_stat_t stat,
    output bvm_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_REGRD   = 8'b0000_0010,
        S_SPRD    = 8'b0000_0100,
        S_POP     = 8'b0000_1000,
        S_POPWAIT = 8'b0001_0000,
        S_ALU     = 8'b0010_0000,
        S_PUSH    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_REGRD;
                end
            end
            S_REGRD:
            begin
                cmd.take_ops = 1'b1;
                state_next   = S_SPRD;
            end
            S_SPRD:
            begin
                if (stat.halted)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    if (stat.is_push)
                    begin
                        cnt_next   = 3'd3;
                        state_next = S_PUSH;
                    end
                    else if (stat.is_arith)
                    begin
                        cnt_next   = 3'd7;
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_POP:
            begin
                cmd.pop  = 1'b1;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    state_next = S_POPWAIT;
                end
            end
            S_POPWAIT:
            begin
                state_next = S_ALU;
            end
            S_ALU:
            begin
                cmd.alu    = 1'b1;
                cnt_next   = 3'd3;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    cmd.push_last = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> hw/rtl/bytecode_vm_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode machine execute unit
// Executes one decoded instruction per transfer and reports the next pc.
// ----------------------------------------------------------------------------
// The instruction channel (in_ch) takes one decoded instruction per transfer;
// the result channel (out_ch) returns exactly one result per instruction, in
// order, holding the program counter after it, the halt flag and the status
// captured at halt. Instructions are handled one at a time.
// Work after the input transfer, before the result is valid:
//   register, jump, halt and unknown opcodes: register reads and execute,
//   push: four byte writes to the stack,
//   stack add, subtract and multiply: eight byte reads, the arithmetic
//   and four byte writes, all through the single-port byte stack, which
//   sets the rate of stack arithmetic.
// The sequencer is ready for a new instruction in the cycle after the
// previous result has moved into the output register, so a result waiting
// on a stalled receiver does not hold back the next instruction; only a
// second finished result waits.
// Reset clears the program counter, halt state, output valid and the valid
// bits of the register file and stack, so every register and stack byte
// reads as zero until written. Once halted, results repeat the frozen state.
// ----------------------------------------------------------------------------
module bytecode_vm_execute_unit
    import bvm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bvm_in_if.sink    in_ch,
    bvm_out_if.source out_ch
);

    bvm_cmd_t  cmd;
    bvm_stat_t stat;

    // Sequencer: walks each instruction through its phases.
    bvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: register file, byte stack, pc and the output register.
    bvm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (in_ch.mode),
        .reg_a       (in_ch.reg_a),
        .reg_b       (in_ch.reg_b),
        .immediate   (in_ch.immediate),
        .next_pc     (out_ch.next_pc),
        .halted      (out_ch.halted),
        .exit_status (out_ch.exit_status)
    );

endmodule
`default_nettype wire

>>> bench/bytecode_vm_execute_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode machine execute unit testbench
// Feeds decoded instructions into the execute unit and checks every result.
// The bench tracks its own copy of the register file, byte stack, program
// counter and halt state. Stimulus starts with a short directed program,
// then runs random instruction runs, four in ten of them push and arithmetic
// groups. Idling on both channels varies by phase. A halt ends the run.
// ----------------------------------------------------------------------------
module bytecode_vm_execute_unit_tb;
    import bvm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int PHASE_ITEMS   = 240;   // accepted transfers per idling phase
    localparam int DRAIN_SPACING = 600;   // random items between drain pauses
    localparam int SETTLE_CYCLES = 20;    // beyond the slowest opcode latency

    // Opcodes with no defined operation only advance the pc.
    localparam logic [MODE_W-1:0] FIRST_UNUSED_MODE = 4'd9;
    localparam logic [MODE_W-1:0] LAST_UNUSED_MODE  = 4'd15;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [RIDX_W-1:0] reg_a;
        logic [RIDX_W-1:0] reg_b;
        logic [WORD_W-1:0] immediate;
        bit                drain_first;  // hold until all results are back
    } instr_t;

    typedef struct {
        logic [WORD_W-1:0] next_pc;
        logic              halted;
        logic [WORD_W-1:0] exit_status;
    } vm_result_t;

    logic clk;
    logic rst_n;

    bvm_in_if  in_ch ();
    bvm_out_if out_ch ();

    bytecode_vm_execute_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Architectural state as the bench expects it to evolve.
    logic [WORD_W-1:0] vm_regs  [NUM_REGS]    = '{default: '0};
    logic [7:0]        vm_stack [STACK_BYTES] = '{default: '0};
    logic [WORD_W-1:0] vm_pc     = '0;
    logic              vm_halted = 1'b0;
    logic [WORD_W-1:0] vm_status = '0;

    instr_t     pending_instrs [$];
    vm_result_t predicted_results [$];
    instr_t     instr_on_bus;

    int          n_accepted  = 0;
    int          mismatches  = 0;
    int unsigned cycle_count = 0;
    bit          drain_request = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A push bumps the stack pointer first and then writes the byte it
    // addresses; the pointer is a full 32-bit register, the byte address is
    // its value modulo the stack size.
    function automatic void stack_push_byte(input logic [7:0] b);
        vm_regs[SP_IDX] = vm_regs[SP_IDX] + 1;
        vm_stack[vm_regs[SP_IDX] % STACK_BYTES] = b;
    endfunction

    function automatic logic [7:0] stack_pop_byte();
        logic [7:0] b;
        b = vm_stack[vm_regs[SP_IDX] % STACK_BYTES];
        vm_regs[SP_IDX] = vm_regs[SP_IDX] - 1;
        return b;
    endfunction

    // Words go on most significant byte first, so the low byte sits on top.
    function automatic void stack_push_word(input logic [WORD_W-1:0] w);
        for (int i = 3; i >= 0; i--)
            stack_push_byte(w[8*i +: 8]);
    endfunction

    function automatic logic [WORD_W-1:0] stack_pop_word();
        logic [WORD_W-1:0] w;
        for (int i = 0; i < 4; i++)
            w[8*i +: 8] = stack_pop_byte();
        return w;
    endfunction

    function automatic vm_result_t execute_instr(input instr_t it);
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] below;
        vm_result_t        r;
        // Once halted the machine is frozen and every result repeats it.
        if (!vm_halted)
        begin
            case (op_t'(it.mode))
                OP_MOVCONST:
                begin
                    vm_regs[it.reg_a % NUM_REGS] = it.immediate;
                    vm_pc = vm_pc + 2 + CONST_BYTES;
                end
                OP_MOVREG:
                begin
                    vm_regs[it.reg_a % NUM_REGS] = vm_regs[it.reg_b % NUM_REGS];
                    vm_pc = vm_pc + 3;
                end
                OP_PUSH:
                begin
                    stack_push_word(it.immediate);
                    vm_pc = vm_pc + 1 + CONST_BYTES;
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    top   = stack_pop_word();
                    below = stack_pop_word();
                    if (it.mode == OP_ADD)
                        stack_push_word(top + below);
                    else if (it.mode == OP_SUB)
                        stack_push_word(below - top);
                    else
                        stack_push_word(top * below);
                    vm_pc = vm_pc + 1;
                end
                OP_ADDREG:
                begin
                    vm_regs[it.reg_a % NUM_REGS] = vm_regs[it.reg_a % NUM_REGS]
                                                 + vm_regs[it.reg_b % NUM_REGS];
                    vm_pc = vm_pc + 3;
                end
                OP_JMP:
                    vm_pc = it.immediate;
                OP_HALT:
                begin
                    vm_status = vm_regs[STATUS_IDX];
                    vm_halted = 1'b1;
                    vm_pc     = vm_pc + 1;
                end
                default:
                    vm_pc = vm_pc + 1;
            endcase
        end
        r.next_pc     = vm_pc;
        r.halted      = vm_halted;
        r.exit_status = vm_status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    function automatic void add_instr(input logic [MODE_W-1:0] mode,
                                      input logic [RIDX_W-1:0] ra,
                                      input logic [RIDX_W-1:0] rb,
                                      input logic [WORD_W-1:0] imm);
        instr_t it;
        it.mode        = mode;
        it.reg_a       = ra;
        it.reg_b       = rb;
        it.immediate   = imm;
        it.drain_first = drain_request;
        drain_request  = 1'b0;
        pending_instrs.push_back(it);
    endfunction

    // Operand values lean toward the corners where carries and wraps happen.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Stack pointer values, mostly close to the 32-bit wrap and to the stack's own
    // wrap, so pushes and pops cross both boundaries.
    function automatic logic [WORD_W-1:0] random_sp();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 12);
            1:       return $urandom_range(0, 12);
            2:       return STACK_BYTES * $urandom_range(1, 8) - $urandom_range(0, 12);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] random_arith_op();
        case ($urandom_range(0, 2))
            0:       return OP_ADD;
            1:       return OP_SUB;
            default: return OP_MUL;
        endcase
    endfunction

    // Any opcode except halt, which would freeze the machine for the rest
    // of the run.
    function automatic logic [MODE_W-1:0] random_live_mode();
        logic [MODE_W-1:0] m;
        m = $urandom_range(0, 15);
        if (m == OP_HALT)
            m = $urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE);
        return m;
    endfunction

    // Appends one short run of instructions. Four in ten runs are well formed
    // push/arithmetic groups; the rest are register traffic, jumps, unused
    // opcodes, bare arithmetic on whatever the stack holds, and noise.
    function automatic void add_random_run();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                n = $urandom_range(2, 4);
                for (int i = 0; i < n; i++)
                    add_instr(OP_PUSH, $urandom, $urandom, random_word());
                for (int i = 1; i < n; i++)
                    add_instr(random_arith_op(), $urandom, $urandom, $urandom);
            end
            3:
            begin
                add_instr(OP_MOVCONST, $urandom, $urandom, random_word());
                add_instr(OP_MOVREG, $urandom, $urandom, $urandom);
                add_instr(OP_ADDREG, $urandom, $urandom, $urandom);
            end
            4:
            begin
                add_instr(OP_MOVCONST, SP_IDX, $urandom, random_sp());
                add_instr(OP_PUSH, $urandom, $urandom, random_word());
                add_instr(OP_PUSH, $urandom, $urandom, random_word());
                add_instr(random_arith_op(), $urandom, $urandom, $urandom);
            end
            5:
                add_instr(OP_JMP, $urandom, $urandom, random_word());
            6:
                add_instr($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE),
                          $urandom, $urandom, $urandom);
            7:
                add_instr(random_arith_op(), $urandom, $urandom, $urandom);
            8:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_instr(random_live_mode(), $urandom, $urandom, $urandom);
            end
            default:
                add_instr(OP_MOVCONST, STATUS_IDX, $urandom, random_word());
        endcase
    endfunction

    // Directed program: operand extremes, every live opcode, both unused
    // opcode corners, the pc wrapping past the top, the stack pointer
    // wrapping at 2^32 and the stack wrapping on underflow.
    function automatic void add_directed_program();
        add_instr(OP_MOVCONST, 4'd2, 4'd0, 32'hFFFF_FFFF);
        add_instr(OP_MOVCONST, 4'd15, 4'd0, 32'h0000_0000);
        add_instr(OP_MOVREG, 4'd3, 4'd2, 32'h0);
        add_instr(OP_ADDREG, 4'd3, 4'd2, 32'hFFFF_FFFF);   // carry out dropped
        add_instr(OP_ADDREG, 4'd14, 4'd14, 32'h0);         // register plus itself
        add_instr(OP_PUSH, 4'd0, 4'd0, 32'hFFFF_FFFF);
        add_instr(OP_PUSH, 4'd0, 4'd0, 32'h0000_0001);
        add_instr(OP_ADD, 4'd0, 4'd0, 32'h0);              // sum wraps to zero
        add_instr(OP_PUSH, 4'd15, 4'd15, 32'h1234_5678);
        add_instr(OP_SUB, 4'd0, 4'd0, 32'h0);              // borrow through zero
        add_instr(OP_PUSH, 4'd0, 4'd0, 32'h8000_0000);
        add_instr(OP_MUL, 4'd0, 4'd0, 32'hFFFF_FFFF);
        add_instr(OP_JMP, 4'd15, 4'd15, 32'hFFFF_FFFF);
        add_instr(FIRST_UNUSED_MODE, 4'd5, 4'd6, 32'hFFFF_FFFF);  // pc wraps to 0
        add_instr(LAST_UNUSED_MODE, 4'd15, 4'd15, 32'h0);
        add_instr(OP_MOVCONST, SP_IDX, 4'd0, 32'hFFFF_FFFE);
        add_instr(OP_PUSH, 4'd0, 4'd0, 32'hA5A5_5A5A);     // pointer wraps at 2^32
        add_instr(OP_MOVCONST, SP_IDX, 4'd0, 32'h0000_0001);
        add_instr(OP_ADD, 4'd0, 4'd0, 32'h0);              // pops below byte zero
        add_instr(OP_MUL, 4'd0, 4'd0, 32'h0);
        add_instr(OP_MOVREG, SP_IDX, 4'd15, 32'h0);
        add_instr(OP_MOVCONST, STATUS_IDX, 4'd0, 32'hDEAD_BEEF);
        add_instr(OP_JMP, 4'd0, 4'd0, 32'h0000_0000);
    endfunction

    // ------------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------------

    // Phases rotate every PHASE_ITEMS accepted transfers: no idling, sender
    // gaps, receiver stalls, then both at a lower rate.
    function automatic bit idle_roll(input bit for_sender);
        int pct;
        case ((n_accepted / PHASE_ITEMS) % 4)
            0:       pct = 0;
            1:       pct = for_sender ? 53 : 0;
            2:       pct = for_sender ? 0 : 53;
            default: pct = 26;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Instruction driver
    // ------------------------------------------------------------------------
    // The prediction runs at the edge where a transfer completes, in transfer
    // order. A new item is offered only when the bus is empty or the current
    // one was just taken, so valid is assigned once per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.mode      <= '0;
            in_ch.reg_a     <= '0;
            in_ch.reg_b     <= '0;
            in_ch.immediate <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predicted_results.push_back(execute_instr(instr_on_bus));
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_instrs.size() > 0 && !idle_roll(1'b1) &&
                    !(pending_instrs[0].drain_first && predicted_results.size() > 0))
                begin
                    instr_on_bus     = pending_instrs.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.mode      <= instr_on_bus.mode;
                    in_ch.reg_a     <= instr_on_bus.reg_a;
                    in_ch.reg_b     <= instr_on_bus.reg_b;
                    in_ch.immediate <= instr_on_bus.immediate;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field,
                                        input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vm_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual pc 0x%08h",
                             $time, out_ch.next_pc);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("next_pc", want.next_pc, out_ch.next_pc);
                    check_field("halted", WORD_W'(want.halted), WORD_W'(out_ch.halted));
                    check_field("exit_status", want.exit_status, out_ch.exit_status);
                end
            end
            out_ch.ready <= !idle_roll(1'b0);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence control
    // ------------------------------------------------------------------------
    initial
    begin
        int random_start;
        int next_drain;

        // Every block input is known from time zero.
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = '0;
        in_ch.reg_a     = '0;
        in_ch.reg_b     = '0;
        in_ch.immediate = '0;
        out_ch.ready    = 1'b0;

        add_directed_program();

        // The random part opens with a drain pause and repeats it now and
        // then, so the block also starts from a fully idle pipeline.
        random_start  = pending_instrs.size();
        next_drain    = 0;
        while (pending_instrs.size() - random_start < RANDOM_ITEMS)
        begin
            if (pending_instrs.size() - random_start >= next_drain)
            begin
                drain_request = 1'b1;
                next_drain += DRAIN_SPACING;
            end
            add_random_run();
        end

        // Halt freezes the machine for good, so it closes the run: load a
        // status value, halt after a drain, then show that later
        // instructions of random kinds, a second halt included, change nothing.
        add_instr(OP_MOVCONST, STATUS_IDX, $urandom, random_word());
        drain_request = 1'b1;
        add_instr(OP_HALT, $urandom, $urandom, $urandom);
        add_instr(OP_HALT, $urandom, $urandom, $urandom);
        for (int i = 0; i < 10; i++)
            add_instr($urandom_range(0, 15), $urandom, $urandom, $urandom);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_instrs.size() > 0 || in_ch.valid)
            @(posedge clk);
        while (predicted_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_in_if.sv
hw/rtl/bvm_out_if.sv
hw/rtl/bvm_datapath.sv
hw/rtl/bvm_ctrl.sv
hw/rtl/bytecode_vm_execute_unit.sv
bench/bytecode_vm_execute_unit_tb.sv
